[sv/flfa_pkg.sv]
// Package: table sizes, widths, codes and the per-cell control type for the allocator.
`timescale 1ns / 1ps
package flfa_pkg;
	localparam int FREE_ENTRIES = 16;
	localparam int USED_ENTRIES = 16;
	localparam int ADDR_BITS    = 16;
	localparam int LEN_W        = ADDR_BITS + 1;
	localparam int FIDX_W       = $clog2(FREE_ENTRIES);
	localparam int UIDX_W       = $clog2(USED_ENTRIES);
	localparam int FCNT_W       = $clog2(FREE_ENTRIES + 1);
	localparam int UCNT_W       = $clog2(USED_ENTRIES + 1);
	localparam int SCAN_W       = (FCNT_W > UCNT_W) ? FCNT_W : UCNT_W;
	localparam logic [LEN_W-1:0] ARENA_MAX = LEN_W'(1) << ADDR_BITS;

	// fit policy codes
	localparam logic [1:0] FIT_BEST  = 2'd0;
	localparam logic [1:0] FIT_WORST = 2'd1;
	localparam logic [1:0] FIT_FIRST = 2'd2;

	// status codes
	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_NO_FIT  = 2'd1;
	localparam logic [1:0] ST_NO_ADDR = 2'd2;
	localparam logic [1:0] ST_FULL    = 2'd3;

	// operation codes
	localparam logic MODE_ALLOC = 1'b0;
	localparam logic MODE_FREE  = 1'b1;

	// register indexes
	localparam logic REG_FIT   = 1'b0;
	localparam logic REG_ARENA = 1'b1;

	// control of one table cell
	typedef struct packed {
		logic load;
		logic shift;
	} cell_ctl_t;
endpackage

[sv/flfa_cell.sv]
// One table entry: holds a block's start and length, loads or takes its successor's entry.
`timescale 1ns / 1ps
module flfa_cell import flfa_pkg::*; (
	input  logic                 clk,
	input  cell_ctl_t            ctl,
	input  logic [ADDR_BITS-1:0] ld_start,
	input  logic [LEN_W-1:0]     ld_len,
	input  logic [ADDR_BITS-1:0] next_start,
	input  logic [LEN_W-1:0]     next_len,
	output logic [ADDR_BITS-1:0] start,
	output logic [LEN_W-1:0]     len
);
	logic [ADDR_BITS-1:0] start_q;
	logic [LEN_W-1:0]     len_q;

	// shift moves the successor up; load writes a fresh entry
	always_ff @(posedge clk) begin
		if (ctl.shift) begin
			start_q <= next_start;
			len_q   <= next_len;
		end else if (ctl.load) begin
			start_q <= ld_start;
			len_q   <= ld_len;
		end
	end

	assign start = start_q;
	assign len   = len_q;
endmodule

[sv/free_list_fit_allocator.sv]
// Top level: config registers, scan sequencer and the two rows of table cells.
// Flow: an accepted request scans the table up to its entry count (n <= 16), then the
// result is registered and done strobes; a scan stops early on a match or first fit.
// Throughput: one scan step per cycle; busy high until done, no request taken while busy.
// Reset: asynchronous; an init state loads the arena block, busy is high meanwhile.
// done pulses for one cycle; the receiver cannot stall.
`timescale 1ns / 1ps
module free_list_fit_allocator import flfa_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [2:0]           paddr,
	input  logic [31:0]          pwdata,
	output logic [31:0]          prdata,
	output logic                 pready,
	input  logic                 start,
	output logic                 busy,
	input  logic                 mode,
	input  logic [LEN_W-1:0]     request_size,
	input  logic [ADDR_BITS-1:0] block_address,
	output logic                 done,
	output logic [1:0]           status,
	output logic [ADDR_BITS-1:0] result_address
);
	localparam logic [1:0] S_INIT = 2'd0;
	localparam logic [1:0] S_IDLE = 2'd1;
	localparam logic [1:0] S_SCAN = 2'd2;
	localparam logic [1:0] S_DONE = 2'd3;

	logic [1:0]           state_q;
	logic [1:0]           fit_q;
	logic [LEN_W-1:0]     arena_q;
	logic [FCNT_W-1:0]    free_cnt_q;
	logic [UCNT_W-1:0]    used_cnt_q;
	logic [SCAN_W-1:0]    idx_q;
	logic                 found_q;
	logic [SCAN_W-1:0]    pick_q;
	logic [ADDR_BITS-1:0] pick_start_q;
	logic [LEN_W-1:0]     pick_len_q;
	logic                 mode_q;
	logic [LEN_W-1:0]     req_q;
	logic [ADDR_BITS-1:0] addr_q;
	logic                 done_q;
	logic [1:0]           status_q;
	logic [ADDR_BITS-1:0] res_addr_q;

	logic [ADDR_BITS-1:0] f_start [FREE_ENTRIES];
	logic [LEN_W-1:0]     f_len   [FREE_ENTRIES];
	logic [ADDR_BITS-1:0] u_start [USED_ENTRIES];
	logic [LEN_W-1:0]     u_len   [USED_ENTRIES];
	cell_ctl_t            f_ctl   [FREE_ENTRIES];
	cell_ctl_t            u_ctl   [USED_ENTRIES];
	logic [ADDR_BITS-1:0] f_ld_start;
	logic [LEN_W-1:0]     f_ld_len;

	logic                 cfg_wr;
	logic                 accept;
	logic [LEN_W-1:0]     arena_sat;
	logic [LEN_W-1:0]     wr_arena;
	logic                 scan_end;
	logic [ADDR_BITS-1:0] rd_start;
	logic [LEN_W-1:0]     rd_len;
	logic                 fits;
	logic                 better;
	logic                 hit;
	logic [LEN_W-1:0]     rem_len;
	logic                 alloc_ok;
	logic                 free_ok;

	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite & pready;
	assign accept = start & ~busy;
	assign busy   = (state_q != S_IDLE);

	// register read
	always_comb begin
		prdata = '0;
		if (paddr[2] == REG_FIT)
			prdata[1:0] = fit_q;
		else
			prdata[LEN_W-1:0] = arena_q;
	end

	// arena saturates to the address space
	assign wr_arena  = pwdata[LEN_W-1:0];
	assign arena_sat = (state_q == S_INIT) ?
		((arena_q > ARENA_MAX) ? ARENA_MAX : arena_q) :
		((wr_arena > ARENA_MAX) ? ARENA_MAX : wr_arena);

	// scan step: read the entry under the cursor
	always_comb begin
		if (mode_q == MODE_ALLOC) begin
			scan_end = (idx_q == SCAN_W'(free_cnt_q));
			rd_start = f_start[idx_q[FIDX_W-1:0]];
			rd_len   = f_len[idx_q[FIDX_W-1:0]];
		end else begin
			scan_end = (idx_q == SCAN_W'(used_cnt_q));
			rd_start = u_start[idx_q[UIDX_W-1:0]];
			rd_len   = u_len[idx_q[UIDX_W-1:0]];
		end
		fits   = (rd_len >= req_q);
		better = (fit_q == FIT_WORST) ? (rd_len > pick_len_q) : (rd_len < pick_len_q);
		hit    = (rd_start == addr_q);
	end

	// outcome of the finished scan
	assign rem_len  = pick_len_q - req_q;
	assign alloc_ok = (mode_q == MODE_ALLOC) && (req_q != '0) && found_q &&
		(used_cnt_q != UCNT_W'(USED_ENTRIES));
	assign free_ok  = (mode_q == MODE_FREE) && found_q &&
		(free_cnt_q != FCNT_W'(FREE_ENTRIES));

	// free table cell controls
	always_comb begin
		f_ld_start = pick_start_q + req_q[ADDR_BITS-1:0];
		f_ld_len   = rem_len;
		if (free_ok) begin
			f_ld_start = pick_start_q;
			f_ld_len   = pick_len_q;
		end
		if (cfg_wr && (paddr[2] == REG_ARENA) || state_q == S_INIT) begin
			f_ld_start = '0;
			f_ld_len   = arena_sat;
		end
		for (int i = 0; i < FREE_ENTRIES; i++) begin
			f_ctl[i].load  = 1'b0;
			f_ctl[i].shift = 1'b0;
			if ((cfg_wr && (paddr[2] == REG_ARENA) || state_q == S_INIT) && i == 0)
				f_ctl[i].load = 1'b1;
			if (state_q == S_DONE && alloc_ok) begin
				if (rem_len == '0)
					f_ctl[i].shift = (i >= int'(pick_q)) && (i + 1 < int'(free_cnt_q));
				else
					f_ctl[i].load = (i == int'(pick_q));
			end
			if (state_q == S_DONE && free_ok)
				f_ctl[i].load = (i == int'(free_cnt_q));
		end
	end

	// used table cell controls
	always_comb begin
		for (int i = 0; i < USED_ENTRIES; i++) begin
			u_ctl[i].load  = (state_q == S_DONE) && alloc_ok && (i == int'(used_cnt_q));
			u_ctl[i].shift = (state_q == S_DONE) && free_ok &&
				(i >= int'(pick_q)) && (i + 1 < int'(used_cnt_q));
		end
	end

	// row of free table cells
	for (genvar g = 0; g < FREE_ENTRIES; g++) begin : g_free
		flfa_cell u_cell (
			.clk        (clk),
			.ctl        (f_ctl[g]),
			.ld_start   (f_ld_start),
			.ld_len     (f_ld_len),
			.next_start ((g + 1 < FREE_ENTRIES) ? f_start[(g + 1) % FREE_ENTRIES] : '0),
			.next_len   ((g + 1 < FREE_ENTRIES) ? f_len[(g + 1) % FREE_ENTRIES] : '0),
			.start      (f_start[g]),
			.len        (f_len[g])
		);
	end

	// row of used table cells
	for (genvar g = 0; g < USED_ENTRIES; g++) begin : g_used
		flfa_cell u_cell (
			.clk        (clk),
			.ctl        (u_ctl[g]),
			.ld_start   (pick_start_q),
			.ld_len     (req_q),
			.next_start ((g + 1 < USED_ENTRIES) ? u_start[(g + 1) % USED_ENTRIES] : '0),
			.next_len   ((g + 1 < USED_ENTRIES) ? u_len[(g + 1) % USED_ENTRIES] : '0),
			.start      (u_start[g]),
			.len        (u_len[g])
		);
	end

	// sequencer, counts and config
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_INIT;
			fit_q      <= FIT_BEST;
			arena_q    <= ARENA_MAX;
			free_cnt_q <= '0;
			used_cnt_q <= '0;
			done_q     <= 1'b0;
			idx_q      <= '0;
			found_q    <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (cfg_wr) begin
				if (paddr[2] == REG_FIT) begin
					fit_q <= pwdata[1:0];
				end else begin
					arena_q    <= wr_arena;
					free_cnt_q <= FCNT_W'(arena_sat != '0);
					used_cnt_q <= '0;
				end
			end
			unique case (state_q)
				S_INIT: begin
					free_cnt_q <= FCNT_W'(arena_sat != '0);
					used_cnt_q <= '0;
					state_q    <= S_IDLE;
				end
				S_IDLE: begin
					if (accept) begin
						idx_q   <= '0;
						found_q <= 1'b0;
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (scan_end) begin
						state_q <= S_DONE;
					end else begin
						idx_q <= idx_q + 1'b1;
						if (mode_q == MODE_ALLOC) begin
							if (fits && (!found_q || better || fit_q == FIT_FIRST))
								found_q <= 1'b1;
							if (fits && fit_q == FIT_FIRST)
								state_q <= S_DONE;
						end else if (hit) begin
							found_q <= 1'b1;
							state_q <= S_DONE;
						end
					end
				end
				S_DONE: begin
					done_q  <= 1'b1;
					state_q <= S_IDLE;
					if (alloc_ok) begin
						used_cnt_q <= used_cnt_q + 1'b1;
						if (rem_len == '0)
							free_cnt_q <= free_cnt_q - 1'b1;
					end
					if (free_ok) begin
						free_cnt_q <= free_cnt_q + 1'b1;
						used_cnt_q <= used_cnt_q - 1'b1;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// request capture, pick tracking and result registers
	always_ff @(posedge clk) begin
		if (accept) begin
			mode_q <= mode;
			req_q  <= request_size;
			addr_q <= block_address;
		end
		if (state_q == S_SCAN && !scan_end) begin
			if (mode_q == MODE_ALLOC) begin
				if (fits && (!found_q || better || fit_q == FIT_FIRST)) begin
					pick_q       <= idx_q;
					pick_start_q <= rd_start;
					pick_len_q   <= rd_len;
				end
			end else if (hit && !found_q) begin
				pick_q       <= idx_q;
				pick_start_q <= rd_start;
				pick_len_q   <= rd_len;
			end
		end
		if (state_q == S_DONE) begin
			if (mode_q == MODE_ALLOC) begin
				res_addr_q <= '0;
				if (req_q == '0 || !found_q)
					status_q <= ST_NO_FIT;
				else if (!alloc_ok)
					status_q <= ST_FULL;
				else begin
					status_q   <= ST_OK;
					res_addr_q <= pick_start_q;
				end
			end else begin
				res_addr_q <= addr_q;
				if (!found_q)
					status_q <= ST_NO_ADDR;
				else if (!free_ok)
					status_q <= ST_FULL;
				else
					status_q <= ST_OK;
			end
		end
	end

	assign done           = done_q;
	assign status         = status_q;
	assign result_address = res_addr_q;

`ifndef SYNTHESIS
	a_done_after_finish: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(state_q) == S_DONE) else $error("result strobe without finished scan");
	a_accept_starts_scan: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == S_SCAN) else $error("accepted request did not start a scan");
	a_free_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DONE |=> free_cnt_q <= FCNT_W'(FREE_ENTRIES))
		else $error("free table count overflow");
	a_used_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DONE |=> used_cnt_q <= UCNT_W'(USED_ENTRIES))
		else $error("used table count overflow");
`endif
endmodule

[dv/free_list_fit_allocator_test.sv]
// Testbench: self-checking random and directed test of the free-list fit allocator.
`timescale 1ns / 1ps
module free_list_fit_allocator_test;
	import flfa_pkg::*;

	// one expected allocator response
	typedef struct {
		logic [1:0]           status;
		logic [ADDR_BITS-1:0] address;
	} response_t;

	// response predictor and checker
	class alloc_scoreboard;
		logic [1:0]           policy;
		logic [LEN_W-1:0]     arena;
		logic [ADDR_BITS-1:0] fstart [FREE_ENTRIES];
		logic [LEN_W-1:0]     flen   [FREE_ENTRIES];
		int                   fcount;
		logic [ADDR_BITS-1:0] ustart [USED_ENTRIES];
		logic [LEN_W-1:0]     ulen   [USED_ENTRIES];
		int                   ucount;
		response_t            pending [$];
		int                   mismatches;

		function void clear_tables();
			logic [LEN_W-1:0] len;
			len = (arena > ARENA_MAX) ? ARENA_MAX : arena;
			ucount = 0;
			fcount = (len == 0) ? 0 : 1;
			fstart[0] = '0;
			flen[0] = len;
		endfunction

		function void write_reg(logic idx, logic [31:0] value);
			if (idx == REG_FIT) begin
				policy = value[1:0];
			end else begin
				arena = value[LEN_W-1:0];
				clear_tables();
			end
		endfunction

		function int pick_block(logic [LEN_W-1:0] req);
			int pick;
			pick = -1;
			for (int i = 0; i < fcount; i++) begin
				if (flen[i] < req) continue;
				if (policy == FIT_FIRST) return i;
				if (pick < 0) pick = i;
				else if (policy == FIT_WORST) begin
					if (flen[i] > flen[pick]) pick = i;
				end else if (flen[i] < flen[pick]) pick = i;
			end
			return pick;
		endfunction

		// note an accepted request and queue its response
		function void note_request(logic m, logic [LEN_W-1:0] req, logic [ADDR_BITS-1:0] addr);
			response_t r;
			int k;
			if (m == MODE_ALLOC) begin
				r.address = '0;
				k = (req == 0) ? -1 : pick_block(req);
				if (k < 0) r.status = ST_NO_FIT;
				else if (ucount >= USED_ENTRIES) r.status = ST_FULL;
				else begin
					r.status = ST_OK;
					r.address = fstart[k];
					ustart[ucount] = fstart[k];
					ulen[ucount] = req;
					ucount++;
					fstart[k] = fstart[k] + req[ADDR_BITS-1:0];
					flen[k] = flen[k] - req;
					if (flen[k] == 0) begin
						for (int i = k; i + 1 < fcount; i++) begin
							fstart[i] = fstart[i+1];
							flen[i] = flen[i+1];
						end
						fcount--;
					end
				end
			end else begin
				r.address = addr;
				k = -1;
				for (int i = 0; i < ucount; i++)
					if (k < 0 && ustart[i] == addr) k = i;
				if (k < 0) r.status = ST_NO_ADDR;
				else if (fcount >= FREE_ENTRIES) r.status = ST_FULL;
				else begin
					r.status = ST_OK;
					fstart[fcount] = ustart[k];
					flen[fcount] = ulen[k];
					fcount++;
					for (int i = k; i + 1 < ucount; i++) begin
						ustart[i] = ustart[i+1];
						ulen[i] = ulen[i+1];
					end
					ucount--;
				end
			end
			pending.push_back(r);
		endfunction

		function void check_response(logic [1:0] st, logic [ADDR_BITS-1:0] addr);
			response_t e;
			if (pending.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected response status %0d addr %0h", st, addr);
				return;
			end
			e = pending.pop_front();
			if (e.status !== st || e.address !== addr) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch: expected status %0d addr %0h, got status %0d addr %0h",
						e.status, e.address, st, addr);
			end
		endfunction
	endclass

	logic                 clk, arst_n;
	logic                 psel, penable, pwrite;
	logic [2:0]           paddr;
	logic [31:0]          pwdata, prdata;
	logic                 pready;
	logic                 start, busy, mode, done;
	logic [LEN_W-1:0]     request_size;
	logic [ADDR_BITS-1:0] block_address;
	logic [1:0]           status;
	logic [ADDR_BITS-1:0] result_address;

	alloc_scoreboard board;
	bit   calm;
	int   cycles;

	free_list_fit_allocator dut (.*);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// collect responses
	always @(posedge clk) begin
		if (arst_n && done) board.check_response(status, result_address);
	end

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 600000) begin
			$display("simulation failed");
			$finish;
		end
	end

	task automatic sender_gap();
		if (!calm && $urandom_range(0, 3) == 0) repeat ($urandom_range(1, 17)) @(posedge clk);
	endtask

	// issue one request and wait for its transfer
	task automatic send(logic m, logic [LEN_W-1:0] req, logic [ADDR_BITS-1:0] addr);
		start <= 1'b1;
		mode <= m;
		request_size <= req;
		block_address <= addr;
		do @(posedge clk); while (busy);
		board.note_request(m, req, addr);
		start <= 1'b0;
		@(posedge clk);
		sender_gap();
	endtask

	task automatic drain();
		while (board.pending.size() != 0) @(posedge clk);
		repeat (25) @(posedge clk);
	endtask

	task automatic write_reg(logic idx, logic [31:0] value);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= (idx == REG_FIT) ? 3'd0 : 3'd4;
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		board.write_reg(idx, value);
		@(posedge clk);
	endtask

	// random request: mostly allocations of small sizes, frees of live blocks
	task automatic random_request(int max_req);
		int r;
		r = $urandom_range(0, 99);
		if (r < 50)
			send(MODE_ALLOC, 17'($urandom_range(1, max_req)), 16'($urandom));
		else if (r < 85 && board.ucount > 0)
			send(MODE_FREE, 17'($urandom), board.ustart[$urandom_range(0, board.ucount - 1)]);
		else if (r < 92)
			send(MODE_FREE, 17'($urandom), 16'($urandom));
		else
			send(MODE_ALLOC, $urandom_range(0, 1) ? 17'($urandom) : 17'd0, 16'($urandom));
	endtask

	initial begin
		logic [31:0] arenas [6];
		board = new();
		board.policy = FIT_BEST;
		board.arena = 17'd65536;
		board.clear_tables();
		cycles = 0;
		calm = 0;
		arst_n = 0;
		psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
		start = 0; mode = 0; request_size = '0; block_address = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: extremes and special cases on the reset arena
		send(MODE_ALLOC, 17'd0, 16'hFFFF);
		send(MODE_ALLOC, 17'h1FFFF, 16'h0);
		send(MODE_ALLOC, 17'd100, 16'h0);
		send(MODE_ALLOC, 17'd65436, 16'h0);
		send(MODE_ALLOC, 17'd1, 16'h0);
		send(MODE_FREE, 17'h1FFFF, 16'd0);
		send(MODE_FREE, 17'd0, 16'd0);
		send(MODE_FREE, 17'd0, 16'hFFFF);
		send(MODE_FREE, 17'd0, 16'd100);
		drain();
		write_reg(REG_ARENA, 32'd0);
		send(MODE_ALLOC, 17'd1, 16'h0);
		drain();
		write_reg(REG_ARENA, 32'h1FFFF);
		write_reg(REG_FIT, 32'd3);
		send(MODE_ALLOC, 17'd65536, 16'h0);
		send(MODE_FREE, 17'd0, 16'd0);
		drain();
		// fill the used table, then free one block at a time until the free table fills
		write_reg(REG_ARENA, 32'd64);
		for (int i = 0; i < 17; i++) send(MODE_ALLOC, 17'd2, 16'h0);
		for (int i = 0; i < 16; i++) send(MODE_FREE, 17'd0, 16'(2 * i));
		drain();

		// random phases across policies and arena sizes
		arenas = '{32'd1, 32'd40, 32'd300, 32'd4096, 32'd65536, 32'h1FFFF};
		for (int ph = 0; ph < 12; ph++) begin
			int sz;
			write_reg(REG_FIT, 32'(ph % 4));
			write_reg(REG_ARENA, arenas[ph % 6]);
			sz = (arenas[ph % 6] > 65536) ? 65536 : arenas[ph % 6];
			if (ph >= 10) calm = 1;
			for (int n = 0; n < 78; n++)
				random_request((sz / 6 > 0) ? sz / 6 : 1);
			drain();
		end

		if (board.mismatches == 0 && board.pending.size() == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end
endmodule
